### design/chorus_modulated_delay_top_defines.svh
// Assertion macros shared by the chorus checker.
`ifndef CHORUS_MODULATED_DELAY_TOP_DEFINES_SVH
`define CHORUS_MODULATED_DELAY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CHMD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chorus port check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CHMD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chorus port check failed");

`endif

### design/chorus_pkg.sv
`timescale 1ns / 1ps

package chorus_pkg;

  // Ring depth must be a power of two.
  localparam int unsigned DELAY_DEPTH  = 2048;
  localparam int unsigned SINE_ENTRIES = 1024;
  localparam int unsigned SAMPLE_BITS  = 16;

  localparam int unsigned IDX_W   = $clog2(DELAY_DEPTH);
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned POS_W   = IDX_W + FRAC_W;
  localparam int unsigned SINE_W  = $clog2(SINE_ENTRIES);
  localparam int unsigned QUARTER = SINE_ENTRIES / 4;
  localparam int unsigned QTR_W   = SINE_W - 2;

  localparam int unsigned PHASE_W    = 24;
  localparam int unsigned BASE_W     = 10;
  localparam int unsigned DEPTH_W    = 10;
  localparam int unsigned MIX_W      = 17;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned DLY_W      = BASE_W + FRAC_W + 1;

  localparam int unsigned MUL_A_W = (SAMPLE_BITS + 1 > 17) ? SAMPLE_BITS + 1 : 17;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [11:0]      FB_COEF = 12'd1311;  // 0.02 in Q16
  localparam logic [MIX_W-1:0] MIX_ONE = 17'h10000;

  localparam logic signed [PROD_W-1:0] HALF_Q8  = {{(PROD_W-8){1'b0}}, 8'h80};
  localparam logic signed [PROD_W-1:0] HALF_Q16 = {{(PROD_W-16){1'b0}}, 16'h8000};
  localparam logic signed [PROD_W-1:0] SAT_HI =
    {{(PROD_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO =
    {{(PROD_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample_in;
    logic    block_end;
  } in_beat_t;

  typedef struct packed {
    sample_t sample_out;
    logic    block_end_out;
  } out_beat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_BASE_DELAY = 2'd1,
    CFG_DEPTH      = 2'd2,
    CFG_MIX        = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_RD0,
    ST_RD1,
    ST_INTERP,
    ST_FB,
    ST_WR,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MUL_LFO,
    MUL_INTERP,
    MUL_FB,
    MUL_MIX
  } mul_sel_e;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     pos_ld;
    logic     rd_next;
    logic     d0_ld;
    logic     dly_ld;
    logic     wr_en;
    logic     out_ld;
  } dp_cmd_t;

  // Quarter wave plus the peak entry, magnitudes in Q15.
  typedef logic [QUARTER:0][14:0] qsine_t;

  function automatic qsine_t build_qsine();
    qsine_t      tab;
    logic [63:0] theta, f, x, x2, t, s;
    logic [1:0]  quad;
    tab = '0;
    for (int k = 0; k <= QUARTER; k++) begin
      theta = (64'(k) << 32) / SINE_ENTRIES;
      quad  = theta[31:30];
      f     = theta & (ONE_Q30 - 64'd1);
      if (quad[0]) begin
        f = ONE_Q30 - f;
      end
      x  = (f * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
        s = 64'd32767;
      end
      tab[k[QTR_W:0]] = s[14:0];
    end
    return tab;
  endfunction

  localparam qsine_t QSINE = build_qsine();

  // Full-period sine from the quarter table by mirror and sign.
  function automatic logic signed [15:0] sine_lookup(input logic [SINE_W-1:0] idx);
    logic [QTR_W:0]     addr;
    logic [14:0]        mag;
    logic signed [15:0] pos;
    if (idx[SINE_W-2]) begin
      addr = (QTR_W+1)'(QUARTER) - {1'b0, idx[QTR_W-1:0]};
    end else begin
      addr = {1'b0, idx[QTR_W-1:0]};
    end
    mag = QSINE[addr];
    pos = {1'b0, mag};
    return idx[SINE_W-1] ? -pos : pos;
  endfunction

  function automatic sample_t sat_sample(input logic signed [PROD_W-1:0] v);
    sample_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

### design/chorus_ram.sv
`timescale 1ns / 1ps

module chorus_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/chorus_ctrl.sv
`timescale 1ns / 1ps

module chorus_ctrl import chorus_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free;
  dp_cmd_t cmd;

  // The output slot is free when empty or when its beat leaves this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.mul_sel = MUL_LFO;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.accept  = 1'b1;
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_LFO;
          state_d     = ST_POS;
        end
      end
      ST_POS: begin
        cmd.pos_ld = 1'b1;
        state_d    = ST_RD0;
      end
      ST_RD0: begin
        cmd.d0_ld   = 1'b1;
        cmd.rd_next = 1'b1;
        state_d     = ST_RD1;
      end
      ST_RD1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INTERP;
        state_d     = ST_INTERP;
      end
      ST_INTERP: begin
        cmd.dly_ld = 1'b1;
        state_d    = ST_FB;
      end
      ST_FB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FB;
        state_d     = ST_WR;
      end
      ST_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MIX;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        // hold the finished sample until the output register can take it
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

### design/chorus_dp.sv
`timescale 1ns / 1ps

module chorus_dp import chorus_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_beat_t              in_beat_i,
  input  dp_cmd_t               cmd_i,
  output out_beat_t             out_beat_o
);

  typedef logic signed [SAMPLE_BITS:0] diff_t;

  logic [PHASE_W-1:0] phase_step_q;
  logic [BASE_W-1:0]  base_delay_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [MIX_W-1:0]   mix_q;

  logic [PHASE_W-1:0] lfo_phase_q;
  logic [IDX_W-1:0]   widx_q;
  logic               full_q;
  logic signed [15:0] sine_q;

  sample_t                    x_q;
  logic                       blk_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [IDX_W-1:0]           r0_q;
  logic [FRAC_W-1:0]          frac_q;
  sample_t                    d0_q;
  sample_t                    delayed_q;
  out_beat_t                  out_q;

  logic [15:0]                lfo;
  logic [MIX_W-1:0]           mix_eff;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod_d;
  logic [DLY_W-1:0]           delay;
  logic [POS_W-1:0]           rpos;
  logic [IDX_W-1:0]           r1;
  logic                       v0, v1;
  logic [IDX_W-1:0]           rd_addr;
  logic [SAMPLE_BITS-1:0]     rd_data;
  sample_t                    d1;
  diff_t                      interp_diff, mix_diff;
  logic signed [PROD_W-1:0]   interp_sum, fb_sum, mix_sum;
  sample_t                    delayed_d, stored, mixed;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PHASE_W'(175);
      base_delay_q <= BASE_W'(720);
      depth_q      <= DEPTH_W'(240);
      mix_q        <= MIX_W'(32768);
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_PHASE_STEP: phase_step_q <= cfg_data_i[PHASE_W-1:0];
        CFG_BASE_DELAY: base_delay_q <= cfg_data_i[BASE_W-1:0];
        CFG_DEPTH:      depth_q      <= cfg_data_i[DEPTH_W-1:0];
        CFG_MIX:        mix_q        <= cfg_data_i[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring pointer, fill flag and LFO. The sine register follows the phase,
  // so it is settled again by the time the next beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfo_phase_q <= '0;
      widx_q      <= '0;
      full_q      <= 1'b0;
      sine_q      <= '0;
    end else begin
      sine_q <= sine_lookup(lfo_phase_q[PHASE_W-1 -: SINE_W]);
      if (cmd_i.wr_en) begin
        widx_q      <= widx_q + 1'b1;
        full_q      <= full_q | (&widx_q);
        lfo_phase_q <= lfo_phase_q + phase_step_q;
      end
    end
  end

  // (1 + sin) / 2 in Q16: flip the sign bit of the Q15 sine.
  assign lfo     = {~sine_q[15], sine_q[14:0]};
  assign mix_eff = (mix_q[MIX_W-1] && |mix_q[MIX_W-2:0]) ? MIX_ONE : mix_q;

  // Read position trails the write pointer by the modulated delay.
  assign delay = DLY_W'({base_delay_q, {FRAC_W{1'b0}}})
               + DLY_W'(prod_q[DEPTH_W+15:FRAC_W]);
  assign rpos  = {widx_q, {FRAC_W{1'b0}}} - POS_W'(delay);
  assign r1    = r0_q + 1'b1;

  // Entries not yet written since reset read as zero.
  assign v0 = full_q || (r0_q < widx_q);
  assign v1 = full_q || (r1 < widx_q);

  assign rd_addr = cmd_i.rd_next ? r1 : rpos[POS_W-1:FRAC_W];
  assign d1      = v1 ? sample_t'(rd_data) : '0;

  assign interp_diff = diff_t'(d1) - diff_t'(d0_q);
  assign mix_diff    = diff_t'(delayed_q) - diff_t'(x_q);

  // Shared multiplier operand select.
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_LFO: begin
        mul_a = MUL_A_W'($signed({1'b0, lfo}));
        mul_b = MUL_B_W'($signed({1'b0, depth_q}));
      end
      MUL_INTERP: begin
        mul_a = MUL_A_W'(interp_diff);
        mul_b = MUL_B_W'($signed({1'b0, frac_q}));
      end
      MUL_FB: begin
        mul_a = MUL_A_W'(delayed_q);
        mul_b = MUL_B_W'($signed({1'b0, FB_COEF}));
      end
      MUL_MIX: begin
        mul_a = MUL_A_W'(mix_diff);
        mul_b = MUL_B_W'($signed({1'b0, mix_eff}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // d0*256 + (d1-d0)*f, rounded half up back to whole samples.
  assign interp_sum = (PROD_W'(d0_q) <<< FRAC_W) + prod_q + HALF_Q8;
  assign delayed_d  = interp_sum[FRAC_W +: SAMPLE_BITS];

  assign fb_sum  = PROD_W'(x_q) + ((prod_q + HALF_Q16) >>> 16);
  assign stored  = sat_sample(fb_sum);
  assign mix_sum = PROD_W'(x_q) + ((prod_q + HALF_Q16) >>> 16);
  assign mixed   = sat_sample(mix_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q   <= in_beat_i.sample_in;
      blk_q <= in_beat_i.block_end;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.pos_ld) begin
      r0_q   <= rpos[POS_W-1:FRAC_W];
      frac_q <= rpos[FRAC_W-1:0];
    end
    if (cmd_i.d0_ld) begin
      d0_q <= v0 ? sample_t'(rd_data) : '0;
    end
    if (cmd_i.dly_ld) begin
      delayed_q <= delayed_d;
    end
    if (cmd_i.out_ld) begin
      out_q.sample_out    <= mixed;
      out_q.block_end_out <= blk_q;
    end
  end

  chorus_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DELAY_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (widx_q),
    .wr_data_i (stored),
    .rd_en_i   (cmd_i.pos_ld | cmd_i.rd_next),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_beat_o = out_q;

endmodule

### design/chorus_modulated_delay_top.sv
`timescale 1ns / 1ps

// Chorus: one signed sample per input beat goes through a sine-LFO modulated,
// linearly interpolated delay line with light feedback, and one mixed sample
// comes out per input beat, in order. The block takes a new sample only
// once it is done with the last: a controller walks each sample through a
// single shared multiplier (LFO depth, interpolation, feedback, dry/wet
// mix) and two successive reads of the single-read-port ring RAM. The
// result sits in an output register, so the next sample is taken while it
// waits; a stalled output holds the block only once a second result is
// ready. The ring needs no clearing after reset: slots not yet written read
// as zero. Write the registers only while the block is idle.
module chorus_modulated_delay_top import chorus_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_beat_o
);

  dp_cmd_t cmd;

  chorus_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  chorus_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .out_beat_o  (out_beat_o)
  );

endmodule

### design/chorus_chk.sv
`timescale 1ns / 1ps
`include "chorus_modulated_delay_top_defines.svh"

module chorus_chk import chorus_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  // A taken beat keeps the input closed while the sample is worked on.
  `CHMD_ASSERT_NXT(a_busy_after_beat, in_valid_i && !in_stall_o, in_stall_o)

  // A result only appears at the end of work on a sample.
  `CHMD_ASSERT_IMP(a_result_from_work, $rose(out_valid_o), $past(in_stall_o))

  // A stalled result stays put.
  `CHMD_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_beat_o))

endmodule

bind chorus_modulated_delay_top chorus_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);
